@@ sv/kots_pkg.sv @@
// Shared constants, action codes and controller/datapath interface types
// for the key offset table search block. No dependencies.
package kots_pkg;

  localparam int DEPTH        = 1024;
  localparam int RECORD_BYTES = 29;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int ACT_W = 2;
  localparam int KEY_W = 24;
  localparam int REC_W = 10;
  localparam int OFF_W = 15;

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LIN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BIN  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] rec;
  } sorted_entry_t;

  typedef struct packed {
    logic capture;
    logic lin_init;
    logic lin_run;
    logic bin_init;
    logic bin_probe;
    logic bin_update;
    logic sh_init;
    logic sh_run;
    logic insert;
    logic res_hit_lin;
    logic res_hit_bin;
    logic res_miss;
    logic res_full;
    logic post;
  } kots_cmd_t;

  typedef struct packed {
    logic full;
    logic is_load;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic lin_hit;
    logic lin_miss;
    logic bin_match;
    logic sh_done;
    logic out_free;
  } kots_status_t;

endpackage

@@ sv/key_offset_table_search.sv @@
// Top level of the key offset table search: controller plus datapath.
// Depends on kots_pkg, kots_ctrl and kots_datapath.
//
// Input channel: in_valid, in_stall, action, key. action 0 appends key as
// the next record and inserts it into a sorted copy; 1 scans the records in
// load order for the first match; 2 binary searches the sorted copy.
// Output channel: out_valid, out_stall, found, table_full, record_number,
// byte_offset. Every accepted item gives exactly one result; byte_offset is
// record_number times 29.
// One item is worked on at a time; in_stall is high from the transfer until
// the result has been moved into the output register. A linear search scans
// the loaded entries in order; a binary search halves the range per probe; a
// load first binary searches for its slot and then shifts the entries above
// it up, one entry per cycle through the single write port of the sorted
// memory.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and its result holds back until the
// output register is free.
// Reset empties the table (entry count to zero) and clears the output valid;
// the key memories need no clearing as only loaded entries are ever read.
module key_offset_table_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kots_pkg::ACT_W-1:0]  action,
  input  logic [kots_pkg::KEY_W-1:0]  key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic                        table_full,
  output logic [kots_pkg::REC_W-1:0]  record_number,
  output logic [kots_pkg::OFF_W-1:0]  byte_offset
);
  import kots_pkg::*;

  kots_cmd_t    cmd;
  kots_status_t status;

  kots_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kots_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .key           (key),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .found         (found),
    .table_full    (table_full),
    .record_number (record_number),
    .byte_offset   (byte_offset)
  );

  // an accepted item always blocks the input for at least the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transfer");

  // never overwrite a result the receiver has not taken
  a_post_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> status.out_free)
    else $error("result posted over a waiting result");

  a_full_result_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !found && record_number == '0 && byte_offset == '0)
    else $error("refused load carries a record");

  a_one_result_step: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.res_hit_lin, cmd.res_hit_bin, cmd.insert, cmd.res_full,
                cmd.res_miss}) <= 1)
    else $error("more than one result source in a cycle");

endmodule

@@ sv/kots_ctrl.sv @@
// Sequencing state machine for the key offset table search.
// Depends on kots_pkg for action codes and the command/status structs.
module kots_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [kots_pkg::ACT_W-1:0] action,
  output logic                      in_stall,
  input  kots_pkg::kots_status_t    status,
  output kots_pkg::kots_cmd_t       cmd
);
  import kots_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LIN       = 4'd1;
  localparam logic [3:0] S_BIN_ISSUE = 4'd2;
  localparam logic [3:0] S_BIN_CMP   = 4'd3;
  localparam logic [3:0] S_BIN_CHECK = 4'd4;
  localparam logic [3:0] S_SHIFT     = 4'd5;
  localparam logic [3:0] S_POST      = 4'd6;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (action == ACT_LOAD) begin
            if (status.full) begin
              cmd.res_full = 1'b1;
              state_next   = S_POST;
            end else begin
              cmd.bin_init = 1'b1;
              state_next   = S_BIN_ISSUE;
            end
          end else if (action == ACT_LIN) begin
            cmd.lin_init = 1'b1;
            state_next   = S_LIN;
          end else if (action == ACT_BIN) begin
            cmd.bin_init = 1'b1;
            state_next   = S_BIN_ISSUE;
          end else begin
            cmd.res_miss = 1'b1;
            state_next   = S_POST;
          end
        end
      end
      S_LIN: begin
        priority if (status.lin_hit) begin
          cmd.res_hit_lin = 1'b1;
          state_next      = S_POST;
        end else if (status.lin_miss) begin
          cmd.res_miss = 1'b1;
          state_next   = S_POST;
        end else begin
          cmd.lin_run = 1'b1;
        end
      end
      S_BIN_ISSUE: begin
        priority if (status.lo_lt_hi) begin
          cmd.bin_probe = 1'b1;
          state_next    = S_BIN_CMP;
        end else if (status.is_load) begin
          cmd.sh_init = 1'b1;
          state_next  = S_SHIFT;
        end else if (status.lo_lt_cnt) begin
          state_next = S_BIN_CHECK;
        end else begin
          cmd.res_miss = 1'b1;
          state_next   = S_POST;
        end
      end
      S_BIN_CMP: begin
        cmd.bin_update = 1'b1;
        state_next     = S_BIN_ISSUE;
      end
      S_BIN_CHECK: begin
        if (status.bin_match) begin
          cmd.res_hit_bin = 1'b1;
        end else begin
          cmd.res_miss = 1'b1;
        end
        state_next = S_POST;
      end
      S_SHIFT: begin
        if (status.sh_done) begin
          cmd.insert = 1'b1;
          state_next = S_POST;
        end else begin
          cmd.sh_run = 1'b1;
        end
      end
      S_POST: begin
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/kots_datapath.sv @@
// Key memories, search counters, result staging and output register.
// Depends on kots_pkg; driven by kots_ctrl through the command struct.
module kots_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [kots_pkg::ACT_W-1:0]  action,
  input  logic [kots_pkg::KEY_W-1:0]  key,
  input  kots_pkg::kots_cmd_t         cmd,
  output kots_pkg::kots_status_t      status,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        found,
  output logic                        table_full,
  output logic [kots_pkg::REC_W-1:0]  record_number,
  output logic [kots_pkg::OFF_W-1:0]  byte_offset
);
  import kots_pkg::*;

  logic [ACT_W-1:0] action_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count;

  // load-order key memory
  logic [KEY_W-1:0] ord_mem [DEPTH];
  logic [KEY_W-1:0] ord_q;
  logic [IDX_W-1:0] ord_ra;

  // sorted copy with record numbers
  sorted_entry_t    srt_mem [DEPTH];
  sorted_entry_t    srt_q;
  sorted_entry_t    srt_wd;
  logic [IDX_W-1:0] srt_ra;
  logic [IDX_W-1:0] srt_wa;
  logic             srt_we;

  logic [CNT_W-1:0] lin_idx;
  logic             lin_v;
  logic [IDX_W-1:0] lin_ridx;

  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_c;
  logic             go_right;

  logic [CNT_W-1:0] sh;
  logic [CNT_W-1:0] sh_dec;
  logic             shv;
  logic [IDX_W-1:0] sh_wa;

  logic             res_found;
  logic             res_full;
  logic [REC_W-1:0] res_rec;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_c    = mid_sum[CNT_W:1];
  assign sh_dec   = sh - CNT_W'(1);
  assign go_right = (srt_q.key < key_q) || ((action_q == ACT_LOAD) && (srt_q.key == key_q));

  assign status.full      = (count == CNT_W'(DEPTH));
  assign status.is_load   = (action_q == ACT_LOAD);
  assign status.lo_lt_hi  = (lo < hi);
  assign status.lo_lt_cnt = (lo < count);
  assign status.lin_hit   = lin_v && (ord_q == key_q);
  assign status.lin_miss  = !lin_v && (lin_idx >= count);
  assign status.bin_match = (srt_q.key == key_q);
  assign status.sh_done   = !shv && (sh == lo);
  assign status.out_free  = !out_valid || !out_stall;

  assign ord_ra = lin_idx[IDX_W-1:0];

  always_comb begin
    priority if (cmd.bin_probe) begin
      srt_ra = mid_c[IDX_W-1:0];
    end else if (cmd.sh_run) begin
      srt_ra = sh_dec[IDX_W-1:0];
    end else begin
      srt_ra = lo[IDX_W-1:0];
    end
  end

  always_comb begin
    srt_we = 1'b0;
    srt_wa = sh_wa;
    srt_wd = srt_q;
    priority if (cmd.insert) begin
      srt_we = 1'b1;
      srt_wa = lo[IDX_W-1:0];
      srt_wd = '{key: key_q, rec: count[IDX_W-1:0]};
    end else if (shv) begin
      srt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ord_mem[count[IDX_W-1:0]] <= key_q;
    end
    ord_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    srt_q <= srt_mem[srt_ra];
  end

  // item capture and binary search bounds
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      key_q    <= key;
    end
    if (cmd.bin_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.bin_update) begin
      if (go_right) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.bin_probe) begin
      mid <= mid_c;
    end
    lin_ridx <= lin_idx[IDX_W-1:0];
    sh_wa    <= sh[IDX_W-1:0];
  end

  // scan and shift counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      lin_idx <= '0;
      lin_v   <= 1'b0;
      sh      <= '0;
      shv     <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.lin_init) begin
        lin_idx <= '0;
        lin_v   <= 1'b0;
      end else if (cmd.lin_run) begin
        if (lin_idx < count) begin
          lin_idx <= lin_idx + CNT_W'(1);
          lin_v   <= 1'b1;
        end else begin
          lin_v <= 1'b0;
        end
      end
      if (cmd.sh_init) begin
        sh  <= count;
        shv <= 1'b0;
      end else if (cmd.sh_run && (sh > lo)) begin
        sh  <= sh_dec;
        shv <= 1'b1;
      end else begin
        shv <= 1'b0;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    priority if (cmd.res_hit_lin) begin
      res_found <= 1'b1;
      res_full  <= 1'b0;
      res_rec   <= REC_W'(lin_ridx);
    end else if (cmd.res_hit_bin) begin
      res_found <= 1'b1;
      res_full  <= 1'b0;
      res_rec   <= REC_W'(srt_q.rec);
    end else if (cmd.insert) begin
      res_found <= 1'b1;
      res_full  <= 1'b0;
      res_rec   <= REC_W'(count[IDX_W-1:0]);
    end else if (cmd.res_full) begin
      res_found <= 1'b0;
      res_full  <= 1'b1;
      res_rec   <= '0;
    end else if (cmd.res_miss) begin
      res_found <= 1'b0;
      res_full  <= 1'b0;
      res_rec   <= '0;
    end else begin
      res_found <= res_found;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      found         <= res_found;
      table_full    <= res_full;
      record_number <= res_rec;
      byte_offset   <= OFF_W'(OFF_W'(res_rec) * OFF_W'(RECORD_BYTES));
    end
  end

endmodule

@@ sim/tb.sv @@
// Self-checking bench for key_offset_table_search: loads, linear and binary
// searches, checked against an in-bench table model. Needs kots_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import kots_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP_ACCOUNT = 24'd9999999;
  localparam int RANDOM_ITEMS = 560;
  localparam int IDLE_LIMIT   = 8000;
  localparam int DRAIN_CYCLES = DEPTH + 64;

  typedef struct packed {
    logic             found;
    logic             table_full;
    logic [REC_W-1:0] rec;
    logic [OFF_W-1:0] off;
  } lookup_result_t;

  class table_scoreboard;
    logic [KEY_W-1:0] load_keys[DEPTH];
    logic [KEY_W-1:0] ordered_keys[DEPTH];
    logic [IDX_W-1:0] ordered_recs[DEPTH];
    int unsigned      loaded;
    lookup_result_t   awaited[$];
    int               errors;
    int               checked;

    function new();
      loaded  = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function lookup_result_t make_result(bit hit, bit full, int unsigned rec);
      lookup_result_t r;
      r.found      = hit;
      r.table_full = full;
      r.rec        = REC_W'(rec);
      r.off        = OFF_W'(rec * RECORD_BYTES);
      return r;
    endfunction

    // first sorted position holding a key >= k, or > k when past_equal is set
    function int unsigned lower_bound(logic [KEY_W-1:0] k, bit past_equal);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = loaded;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (ordered_keys[mid] < k || (past_equal && ordered_keys[mid] == k))
          lo = mid + 1;
        else
          hi = mid;
      end
      return lo;
    endfunction

    function void note_input(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k);
      int unsigned pos;
      int unsigned i;
      lookup_result_t r;
      r = make_result(1'b0, 1'b0, 0);
      case (act)
        ACT_LOAD: begin
          if (loaded >= DEPTH) begin
            r = make_result(1'b0, 1'b1, 0);
          end else begin
            load_keys[loaded] = k;
            pos = lower_bound(k, 1'b1);
            // shift the upper part up by one to open the slot
            for (i = loaded; i > pos; i--) begin
              ordered_keys[i] = ordered_keys[i-1];
              ordered_recs[i] = ordered_recs[i-1];
            end
            ordered_keys[pos] = k;
            ordered_recs[pos] = IDX_W'(loaded);
            r = make_result(1'b1, 1'b0, loaded);
            loaded++;
          end
        end
        ACT_LIN: begin
          for (i = 0; i < loaded; i++) begin
            if (load_keys[i] == k) begin
              r = make_result(1'b1, 1'b0, i);
              break;
            end
          end
        end
        ACT_BIN: begin
          pos = lower_bound(k, 1'b0);
          if (pos < loaded && ordered_keys[pos] == k)
            r = make_result(1'b1, 1'b0, ordered_recs[pos]);
        end
        default: ;
      endcase
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected transfer found=%0b full=%0b rec=%0d off=%0d",
                         got.found, got.table_full, got.rec, got.off));
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0b, expected %0b", got.found, want.found));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full %0b, expected %0b", got.table_full, want.table_full));
      if (got.rec !== want.rec)
        report($sformatf("record_number %0d, expected %0d", got.rec, want.rec));
      if (got.off !== want.off)
        report($sformatf("byte_offset %0d, expected %0d", got.off, want.off));
      checked++;
    endtask
  endclass

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] action    = ACT_UNUSED;
  logic [KEY_W-1:0] key       = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             found;
  logic             table_full;
  logic [REC_W-1:0] record_number;
  logic [OFF_W-1:0] byte_offset;
  bit               calm      = 1'b0;

  table_scoreboard sb = new();

  key_offset_table_search dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .key          (key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .table_full   (table_full),
    .record_number(record_number),
    .byte_offset  (byte_offset)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    if (calm)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(4, 40);
    return $urandom_range(0, 2);
  endfunction

  // mostly keys already loaded or their neighbours, so searches hit
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (sb.loaded > 0 && r < 45)
      return sb.load_keys[$urandom_range(0, sb.loaded - 1)];
    if (sb.loaded > 0 && r < 60)
      return sb.load_keys[$urandom_range(0, sb.loaded - 1)] ^ KEY_W'($urandom_range(1, 3));
    if (r < 68)
      return $urandom_range(0, 1) ? 24'hFFFFFF - KEY_W'($urandom_range(0, 3))
                                   : KEY_W'($urandom_range(0, 3));
    if (r < 72)
      return KEY_TOP_ACCOUNT;
    return KEY_W'($urandom);
  endfunction

  // hold the transfer until the block takes it; valid stays high for a follow-on
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, k);
  endtask

  task automatic send_random(input int items, input bit with_unused);
    int n;
    int pick;
    logic [ACT_W-1:0] act;
    for (n = 0; n < items; n++) begin
      if (n % 64 == 0)
        calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35)
        act = ACT_LOAD;
      else if (pick < 65)
        act = ACT_LIN;
      else if (pick < 95 || !with_unused)
        act = ACT_BIN;
      else
        act = ACT_UNUSED;
      send_item(act, pick_key());
    end
  endtask

  initial begin : stall_driver
    int len;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 8);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 40);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      end
      repeat (len - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{found, table_full, record_number, byte_offset});
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused code, then duplicates and key extremes
    send_item(ACT_LIN, 24'h000000);
    send_item(ACT_BIN, 24'hFFFFFF);
    send_item(ACT_UNUSED, 24'hFFFFFF);
    send_item(ACT_LOAD, 24'h000000);
    send_item(ACT_LOAD, 24'hFFFFFF);
    send_item(ACT_LOAD, 24'h5A5A5A);
    send_item(ACT_LOAD, 24'h000000);
    send_item(ACT_LOAD, 24'hA5A5A5);
    send_item(ACT_LOAD, KEY_TOP_ACCOUNT);
    send_item(ACT_LIN, 24'h000000);
    send_item(ACT_BIN, 24'h000000);
    send_item(ACT_LIN, 24'hFFFFFF);
    send_item(ACT_BIN, 24'hFFFFFF);
    send_item(ACT_BIN, 24'h5A5A5A);
    send_item(ACT_LIN, 24'h123456);
    send_item(ACT_BIN, 24'h123456);
    send_item(ACT_BIN, 24'h000001);
    send_item(ACT_BIN, 24'hFFFFFE);
    send_item(ACT_UNUSED, 24'h000000);
    send_item(ACT_LOAD, 24'h5A5A5A);
    send_item(ACT_BIN, 24'h5A5A5A);
    send_item(ACT_LIN, KEY_TOP_ACCOUNT);

    send_random(RANDOM_ITEMS, 1'b1);

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
sv/kots_pkg.sv
sv/kots_ctrl.sv
sv/kots_datapath.sv
sv/key_offset_table_search.sv
sim/tb.sv
